// ===== src/cdcb_pkg.sv =====
// shared types, sizes and constants of the complex dc blocker
package cdcb_pkg;

    // moving average length, a power of two
    localparam int AVERAGE_LENGTH = 32;
    // floor(log2(AVERAGE_LENGTH))
    localparam int AVG_SHIFT = $clog2(AVERAGE_LENGTH + 1) - 1;
    localparam int DATA_W = 16;
    // exact sum of AVERAGE_LENGTH signed samples
    localparam int SUM_W = DATA_W + $clog2(AVERAGE_LENGTH);
    // extra delay that lines up the first stage tap with the fourth average
    localparam int ALIGN_LEN = AVERAGE_LENGTH - 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] in_i;
        logic signed [DATA_W-1:0] in_q;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_i;
        logic signed [DATA_W-1:0] out_q;
    } out_t;

    // internal complex value between stages
    typedef struct packed {
        logic signed [DATA_W-1:0] i;
        logic signed [DATA_W-1:0] q;
    } iq_t;

endpackage

// ===== src/cdcb_mavg.sv =====
// one moving-average stage for both channels: running sum plus sample history
module cdcb_mavg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  logic             upd,
    input  cdcb_pkg::iq_t    x,
    output cdcb_pkg::iq_t    avg,
    output cdcb_pkg::iq_t    dly
);

    // hist_reg[k] holds the input k+1 samples back
    cdcb_pkg::iq_t hist_reg [cdcb_pkg::AVERAGE_LENGTH];
    logic signed [cdcb_pkg::SUM_W-1:0] sum_i_reg, sum_q_reg;
    logic signed [cdcb_pkg::SUM_W-1:0] sum_i_next, sum_q_next;

    // add the newest, drop the one a full window old
    assign sum_i_next = sum_i_reg + cdcb_pkg::SUM_W'(x.i)
                      - cdcb_pkg::SUM_W'(hist_reg[cdcb_pkg::AVERAGE_LENGTH-1].i);
    assign sum_q_next = sum_q_reg + cdcb_pkg::SUM_W'(x.q)
                      - cdcb_pkg::SUM_W'(hist_reg[cdcb_pkg::AVERAGE_LENGTH-1].q);

    // floor average by arithmetic shift
    assign avg.i = cdcb_pkg::DATA_W'(sum_i_next >>> cdcb_pkg::AVG_SHIFT);
    assign avg.q = cdcb_pkg::DATA_W'(sum_q_next >>> cdcb_pkg::AVG_SHIFT);

    // input from one window minus one sample ago
    assign dly = hist_reg[cdcb_pkg::AVERAGE_LENGTH-2];

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            sum_i_reg <= '0;
            sum_q_reg <= '0;
            for (int k = 0; k < cdcb_pkg::AVERAGE_LENGTH; k++) begin
                hist_reg[k] <= '0;
            end
        end else if (upd) begin
            sum_i_reg <= sum_i_next;
            sum_q_reg <= sum_q_next;
            hist_reg[0] <= x;
            for (int k = 1; k < cdcb_pkg::AVERAGE_LENGTH; k++) begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

endmodule

// ===== src/complex_dc_blocker.sv =====
// top level of the complex dc blocker built from cascaded moving averages
// path: a request goes through x0_reg, a1_reg to a4_reg and out_reg to m_valid
// throughput: one request per cycle unless stalled, set by one register per averaging stage
// stalls: the whole pipeline holds while m_valid is high and m_ready is low
// reset: aresetn (synchronous, active low) clears all histories, sums and valids,
// and sets long_mode; any cfg_we write also clears every history and sum
module complex_dc_blocker (
    input  logic             aclk,
    input  logic             aresetn,
    // input requests
    input  logic             s_valid,
    output logic             s_ready,
    input  cdcb_pkg::in_t    s_data,
    // results
    output logic             m_valid,
    input  logic             m_ready,
    output cdcb_pkg::out_t   m_data,
    // mode register
    input  logic             cfg_we,
    input  logic             cfg_wdata
);

    // saturate a 17-bit difference to the 16-bit output range
    function automatic logic signed [cdcb_pkg::DATA_W-1:0] sat16(
        input logic signed [cdcb_pkg::DATA_W:0] v
    );
        logic signed [cdcb_pkg::DATA_W-1:0] r;
        if (v[cdcb_pkg::DATA_W] != v[cdcb_pkg::DATA_W-1]) begin
            r = v[cdcb_pkg::DATA_W] ? {1'b1, {(cdcb_pkg::DATA_W-1){1'b0}}}
                                    : {1'b0, {(cdcb_pkg::DATA_W-1){1'b1}}};
        end else begin
            r = v[cdcb_pkg::DATA_W-1:0];
        end
        return r;
    endfunction

    // mode: 1 = four averages plus alignment delay, 0 = two averages
    logic long_mode_reg;

    // pipeline advance: moves whenever the result slot is free or being taken
    logic en;
    logic m_valid_reg;
    // vld_reg[k]: pipeline register k holds a live request
    logic [4:0] vld_reg;

    // stage inputs and carried taps
    cdcb_pkg::iq_t x0_reg;              // stage 0 input
    cdcb_pkg::iq_t a1_reg, d1_reg;      // avg0, first stage tap
    cdcb_pkg::iq_t a2_reg, d2_reg;      // avg1, tap
    cdcb_pkg::iq_t a3_reg, b3_reg, d3_reg;  // avg2, avg1, tap
    cdcb_pkg::iq_t a4_reg, b4_reg, d4_reg;  // avg3, avg1, tap
    cdcb_pkg::out_t out_reg;

    // alignment delay of the first stage tap, long mode only
    cdcb_pkg::iq_t al_reg [cdcb_pkg::ALIGN_LEN];

    cdcb_pkg::iq_t avg0, avg1, avg2, avg3;
    cdcb_pkg::iq_t dly0, dly1, dly2, dly3;
    logic [3:0] upd;
    logic al_upd;

    cdcb_pkg::iq_t minu, subt;
    logic signed [cdcb_pkg::DATA_W:0] diff_i, diff_q;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // a stage updates its state only for a live request; stages three and
    // four and the alignment delay stand still in short mode
    assign upd[0] = en && vld_reg[0];
    assign upd[1] = en && vld_reg[1];
    assign upd[2] = en && vld_reg[2] && long_mode_reg;
    assign upd[3] = en && vld_reg[3] && long_mode_reg;
    assign al_upd = en && vld_reg[4] && long_mode_reg;

    cdcb_mavg u_mavg0 (
        .aclk(aclk), .aresetn(aresetn), .clr(cfg_we), .upd(upd[0]),
        .x(x0_reg), .avg(avg0), .dly(dly0)
    );
    cdcb_mavg u_mavg1 (
        .aclk(aclk), .aresetn(aresetn), .clr(cfg_we), .upd(upd[1]),
        .x(a1_reg), .avg(avg1), .dly(dly1)
    );
    cdcb_mavg u_mavg2 (
        .aclk(aclk), .aresetn(aresetn), .clr(cfg_we), .upd(upd[2]),
        .x(a2_reg), .avg(avg2), .dly(dly2)
    );
    cdcb_mavg u_mavg3 (
        .aclk(aclk), .aresetn(aresetn), .clr(cfg_we), .upd(upd[3]),
        .x(a3_reg), .avg(avg3), .dly(dly3)
    );

    // later stage taps are not used by either form
    logic unused_dly;
    assign unused_dly = ^{dly1, dly2, dly3};

    // long form: aligned first stage tap minus fourth average
    // short form: first stage tap minus second average
    always_comb begin
        if (long_mode_reg) begin
            minu = al_reg[cdcb_pkg::ALIGN_LEN-1];
            subt = a4_reg;
        end else begin
            minu = d4_reg;
            subt = b4_reg;
        end
        diff_i = (cdcb_pkg::DATA_W+1)'(minu.i) - (cdcb_pkg::DATA_W+1)'(subt.i)
               + (cdcb_pkg::DATA_W+1)'(unused_dly & 1'b0);
        diff_q = (cdcb_pkg::DATA_W+1)'(minu.q) - (cdcb_pkg::DATA_W+1)'(subt.q);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_mode_reg <= 1'b1;
            vld_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                long_mode_reg <= cfg_wdata;
                vld_reg       <= '0;
            end else if (en) begin
                vld_reg <= {vld_reg[3:0], s_valid};
            end
            if (en) begin
                m_valid_reg <= vld_reg[4] && !cfg_we;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg.i <= s_data.in_i;
            x0_reg.q <= s_data.in_q;
            a1_reg <= avg0;
            d1_reg <= dly0;
            a2_reg <= avg1;
            d2_reg <= d1_reg;
            a3_reg <= avg2;
            b3_reg <= a2_reg;
            d3_reg <= d2_reg;
            a4_reg <= avg3;
            b4_reg <= b3_reg;
            d4_reg <= d3_reg;
            out_reg.out_i <= sat16(diff_i);
            out_reg.out_q <= sat16(diff_q);
        end
    end

    // alignment delay line
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            for (int k = 0; k < cdcb_pkg::ALIGN_LEN; k++) begin
                al_reg[k] <= '0;
            end
        end else if (al_upd) begin
            al_reg[0] <= d4_reg;
            for (int k = 1; k < cdcb_pkg::ALIGN_LEN; k++) begin
                al_reg[k] <= al_reg[k-1];
            end
        end
    end

endmodule
